>>> hw/rtl/lfbp_pkg.sv
// ----------------------------------------------------------------------------
// LSB-first bit packer package
// Shared transaction types, request codes and constants for the bit packer.
// ----------------------------------------------------------------------------
package lfbp_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_WRITE_BITS = 2'd0;
    localparam logic [1:0] REQ_BOUNDED    = 2'd1;
    localparam logic [1:0] REQ_FLUSH      = 2'd2;

    // Bounds above this write a full 32-bit word, all or nothing.
    localparam logic [31:0] WIDE_BOUND = 32'h8000_0000;

    // Reset value of the capacity register.
    localparam logic [23:0] CAP_RESET = 24'd8192;

    // Depth of the command queue between the front and the back end.
    localparam int unsigned FIFO_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] value;
        logic [6:0]  bit_length;
        logic [31:0] maximum;
    } in_item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        last;
        logic [23:0] bit_count;
        logic        overflow;
    } out_item_t;

    // Operation handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    // A classified command: partial writes stop at the capacity, the
    // others are all or nothing.
    typedef struct packed {
        op_t         op;
        logic        partial;
        logic [6:0]  len;
        logic [63:0] data;
    } cmd_t;

endpackage

>>> hw/rtl/lsb_first_bit_packer_core.sv
// ----------------------------------------------------------------------------
// LSB-first bit packer core
// Packs fields least significant bit first into a byte stream and returns
// every completed byte as its own response transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  req       in         req_valid/req_stall   in_item_t  (request transaction)
//  rsp       out        rsp_valid/rsp_stall   out_item_t (one byte or status)
//  cfg       in         cfg_we                cfg_wdata  (capacity in bits)
//
//  A request transaction produces max(1, completed bytes) response
//  transactions, one to eight, and holds the byte emitter until the last;
//  the emitter drives one response per cycle unless rsp stalls, and sets
//  the sustained rate. A request passes the front register, the command
//  queue, the decide, emitter and output registers before rsp_valid rises.
//  rst_n clears the position, partial byte, overflow flag and all valid
//  state at once and loads the capacity with 8192; there is no clearing pass.
//  A stall on rsp backs up into the command queue, and req_stall rises
//  only when the front register holds a command that the queue cannot take.
//
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_core
    import lfbp_pkg::*;
#(
    parameter int unsigned MAX_FIELD_BITS = 64,
    parameter int unsigned POSITION_BITS  = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        req_valid,
    output logic        req_stall,
    input  in_item_t    req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output out_item_t   rsp_data
);

    // Front end to queue.
    logic fifo_full;
    logic push;
    cmd_t push_cmd;

    // Queue to back end.
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // The front end resolves each request into a bit count: write-bits
    // lengths are saturated, bounded integers get the width of their
    // largest value, and requests that write nothing become no-ops.
    lfbp_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // The queue lets the front end keep accepting requests while the back
    // end is busy emitting the bytes of a long write.
    lfbp_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The back end owns the stream state. Its decide stage checks each
    // command against the capacity and updates the position and overflow
    // flag as it takes the command, so commands follow each other without bubbles;
    // the emitter then merges the written bits into the partial byte and
    // hands out completed bytes through the output register.
    lfbp_back #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .POSITION_BITS  (POSITION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

>>> hw/rtl/lfbp_front.sv
// ----------------------------------------------------------------------------
// Bit packer front end
// Accepts request transactions and turns them into write, flush or no-op
// commands with a resolved bit count.
// ----------------------------------------------------------------------------
module lfbp_front
    import lfbp_pkg::*;
#(
    parameter int unsigned MAX_FIELD_BITS = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  in_item_t req_data,
    input  logic     fifo_full,
    output logic     push,
    output cmd_t     push_cmd
);

    logic fr_valid_reg;
    logic fr_valid_next;
    cmd_t fr_cmd_reg;
    cmd_t fr_cmd_next;
    logic accept;

    // Bit width of (maximum - 1), found by halving steps.
    logic [5:0]  bound_bits;

    always_comb
    begin
        logic [31:0] x;
        logic [5:0]  k;
        x = req_data.maximum - 32'd1;
        k = 6'd0;
        for (int i = 4; i >= 0; i--)
        begin
            if ((x >> (1 << i)) != 32'd0)
            begin
                x = x >> (1 << i);
                k = k + 6'(1 << i);
            end
        end
        bound_bits = k + 6'(x[0]);
    end

    always_comb
    begin
        logic [6:0] sat_len;
        sat_len = (req_data.bit_length > 7'(MAX_FIELD_BITS)) ?
                  7'(MAX_FIELD_BITS) : req_data.bit_length;
        fr_cmd_next.op      = OP_NOP;
        fr_cmd_next.partial = 1'b0;
        fr_cmd_next.len     = 7'd0;
        fr_cmd_next.data    = req_data.value;
        case (req_data.req_type)
            REQ_WRITE_BITS:
            begin
                fr_cmd_next.len = sat_len;
                fr_cmd_next.op  = (sat_len == 7'd0) ? OP_NOP : OP_WRITE;
            end
            REQ_BOUNDED:
            begin
                if (req_data.maximum <= 32'd1)
                begin
                    fr_cmd_next.op = OP_NOP;
                end
                else if (req_data.maximum > WIDE_BOUND)
                begin
                    fr_cmd_next.op  = OP_WRITE;
                    fr_cmd_next.len = 7'd32;
                end
                else
                begin
                    fr_cmd_next.op      = OP_WRITE;
                    fr_cmd_next.partial = 1'b1;
                    fr_cmd_next.len     = 7'(bound_bits);
                end
            end
            REQ_FLUSH:
            begin
                fr_cmd_next.op = OP_FLUSH;
            end
            default:
            begin
                fr_cmd_next.op = OP_NOP;
            end
        endcase
    end

    assign req_stall = fr_valid_reg & fifo_full;
    assign accept    = req_valid & ~req_stall;
    assign push      = fr_valid_reg & ~fifo_full;
    assign push_cmd  = fr_cmd_reg;

    always_comb
    begin
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
        else
        begin
            fr_valid_next = fr_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_cmd_reg <= fr_cmd_next;
        end
    end

endmodule

>>> hw/rtl/lfbp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Bit packer command queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module lfbp_cmd_fifo
    import lfbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/lfbp_back.sv
// ----------------------------------------------------------------------------
// Bit packer back end
// Decides how many bits each command writes against the capacity, merges
// them into the partial byte and emits completed bytes one per cycle when rsp is not stalled.
// ----------------------------------------------------------------------------
module lfbp_back
    import lfbp_pkg::*;
#(
    parameter int unsigned MAX_FIELD_BITS = 64,
    parameter int unsigned POSITION_BITS  = 24
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_item_t rsp_data
);

    localparam int unsigned P         = POSITION_BITS;
    localparam int unsigned DATA_BITS = (MAX_FIELD_BITS > 32) ? MAX_FIELD_BITS : 32;
    localparam int unsigned NB        = (DATA_BITS + 7) / 8;
    localparam int unsigned NB_W      = $clog2(NB + 1);
    localparam int unsigned EMIT_W    = NB * 8;
    localparam int unsigned ACC_W     = EMIT_W + 8;
    localparam int unsigned CW        = (P > 24) ? P : 24;
    localparam logic [CW-1:0] POS_MASK    = CW'((64'd1 << P) - 64'd1);
    localparam logic [CW-1:0] CAP_RESET_W = CW'(CAP_RESET);
    localparam logic [P-1:0]  CAP_INIT    =
        P'((CAP_RESET_W > POS_MASK) ? POS_MASK : CAP_RESET_W);

    // ---------------- decide stage ----------------
    logic [P-1:0] cap_reg;
    logic [P-1:0] cap_next;
    logic [P-1:0] pos_reg;
    logic [P-1:0] pos_next;
    logic         ovf_reg;
    logic         ovf_next;
    logic [6:0]   wr_len;

    logic [P:0]   sum;
    logic [P-1:0] room;
    logic         fits;
    logic         room_ok;

    logic         dq_valid_reg;
    logic         dq_valid_next;
    op_t          dq_op_reg;
    logic [6:0]   dq_w_reg;
    logic [63:0]  dq_data_reg;
    logic [2:0]   dq_sh_reg;
    logic [23:0]  dq_count_reg;
    logic         dq_ovf_reg;

    logic         em_load;

    always_comb
    begin
        logic [CW-1:0] cfg_w;
        cfg_w    = CW'(cfg_wdata);
        cap_next = P'((cfg_w > POS_MASK) ? POS_MASK : cfg_w);
    end

    assign sum     = {1'b0, pos_reg} + (P + 1)'(cmd.len);
    assign fits    = (sum <= {1'b0, cap_reg});
    assign room_ok = (cap_reg >= pos_reg);
    assign room    = cap_reg - pos_reg;

    // A partial write that does not fit stops exactly at the capacity, unless the position already lies beyond it.
    always_comb
    begin
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        wr_len   = 7'd0;
        if (cmd.op == OP_WRITE)
        begin
            if (fits)
            begin
                pos_next = sum[P-1:0];
                wr_len   = cmd.len;
            end
            else
            begin
                ovf_next = 1'b1;
                if (cmd.partial && room_ok)
                begin
                    pos_next = cap_reg;
                    wr_len   = room[6:0];
                end
            end
        end
    end

    assign cmd_pop = cmd_valid & (~dq_valid_reg | em_load);

    always_comb
    begin
        if (cmd_pop)
        begin
            dq_valid_next = 1'b1;
        end
        else if (em_load)
        begin
            dq_valid_next = 1'b0;
        end
        else
        begin
            dq_valid_next = dq_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_INIT;
            pos_reg      <= '0;
            ovf_reg      <= 1'b0;
            dq_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cap_next;
            end
            if (cmd_pop)
            begin
                pos_reg <= pos_next;
                ovf_reg <= ovf_next;
            end
            dq_valid_reg <= dq_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            dq_op_reg    <= cmd.op;
            dq_w_reg     <= wr_len;
            dq_data_reg  <= cmd.data;
            dq_sh_reg    <= pos_reg[2:0];
            dq_count_reg <= 24'(pos_next);
            dq_ovf_reg   <= ovf_next;
        end
    end

    // ---------------- pack and emit stage ----------------
    logic [6:0]           pend_reg;
    logic [6:0]           pend_next;
    logic                 em_valid_reg;
    logic                 em_valid_next;
    logic [NB_W-1:0]      em_left_reg;
    logic [NB_W-1:0]      em_left_next;
    logic                 em_bv_reg;
    logic                 em_bv_next;
    logic [EMIT_W-1:0]    em_data_reg;
    logic [EMIT_W-1:0]    em_data_next;
    logic [23:0]          em_count_reg;
    logic                 em_ovf_reg;
    logic                 em_adv;
    logic                 em_last;

    logic [DATA_BITS-1:0] lo_mask;
    logic [DATA_BITS-1:0] masked;
    logic [ACC_W-1:0]     acc;
    logic [7:0]           bit_sum;
    logic [NB_W-1:0]      nb;
    logic [6:0]           pend_after;

    logic                 rsp_valid_reg;
    logic                 rsp_load;
    out_item_t            rsp_data_reg;

    assign lo_mask    = ~({DATA_BITS{1'b1}} << dq_w_reg);
    assign masked     = dq_data_reg[DATA_BITS-1:0] & lo_mask;
    assign acc        = ACC_W'(pend_reg) | (ACC_W'(masked) << dq_sh_reg);
    assign bit_sum    = 8'(dq_sh_reg) + 8'(dq_w_reg);
    assign nb         = NB_W'(bit_sum >> 3);
    assign pend_after = 7'(acc >> {nb, 3'b000});

    always_comb
    begin
        pend_next    = pend_reg;
        em_bv_next   = 1'b0;
        em_left_next = NB_W'(1);
        em_data_next = '0;
        case (dq_op_reg)
            OP_WRITE:
            begin
                pend_next  = pend_after;
                em_bv_next = (nb != '0);
                if (nb != '0)
                begin
                    em_left_next = nb;
                    em_data_next = EMIT_W'(acc);
                end
            end
            OP_FLUSH:
            begin
                em_bv_next = (dq_sh_reg != 3'd0);
                if (dq_sh_reg != 3'd0)
                begin
                    em_data_next = EMIT_W'(pend_reg);
                end
            end
            default:
            begin
                em_bv_next = 1'b0;
            end
        endcase
    end

    assign rsp_load = ~rsp_valid_reg | ~rsp_stall;
    assign em_adv   = em_valid_reg & rsp_load;
    assign em_last  = (em_left_reg == NB_W'(1));
    assign em_load  = dq_valid_reg & (~em_valid_reg | (em_adv & em_last));

    always_comb
    begin
        if (em_load)
        begin
            em_valid_next = 1'b1;
        end
        else if (em_adv && em_last)
        begin
            em_valid_next = 1'b0;
        end
        else
        begin
            em_valid_next = em_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 7'd0;
            em_valid_reg  <= 1'b0;
            em_left_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            em_valid_reg <= em_valid_next;
            if (em_load)
            begin
                pend_reg    <= pend_next;
                em_left_reg <= em_left_next;
            end
            else if (em_adv)
            begin
                em_left_reg <= em_left_reg - NB_W'(1);
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= em_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_load)
        begin
            em_bv_reg    <= em_bv_next;
            em_data_reg  <= em_data_next;
            em_count_reg <= dq_count_reg;
            em_ovf_reg   <= dq_ovf_reg;
        end
        else if (em_adv)
        begin
            em_data_reg <= em_data_reg >> 8;
        end
        if (em_adv)
        begin
            rsp_data_reg.byte_valid <= em_bv_reg;
            rsp_data_reg.out_byte   <= em_data_reg[7:0];
            rsp_data_reg.last       <= em_last;
            rsp_data_reg.bit_count  <= em_count_reg;
            rsp_data_reg.overflow   <= em_ovf_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
